FILE: design/assert_macros.svh
// Assertion macros, included by the top level of the design.
// Clock is taken as "clock" and reset as "reset" in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: design/spx_pkg.sv
// Types and constants of the smart-card PPS exchange block.
// No dependencies; used by the channel interfaces, the parser and the top level.
package spx_pkg;

   localparam int BYTE_W      = 8;
   localparam int NIBBLE_W    = 4;
   localparam int CODE_W      = 2;
   localparam int CSR_INDEX_W = 4;

   localparam logic [BYTE_W-1:0] PPSS_BYTE    = 8'hFF;
   localparam logic [BYTE_W-1:0] PPS0_BASE    = 8'h10;
   localparam int                REQ_BYTES    = 4;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   localparam logic OUT_REQUEST = 1'b0;
   localparam logic OUT_STATUS  = 1'b1;

   localparam logic [CODE_W-1:0] RESULT_OK        = 2'd0;
   localparam logic [CODE_W-1:0] RESULT_BAD_PPSS  = 2'd1;
   localparam logic [CODE_W-1:0] RESULT_BAD_CHECK = 2'd2;
   localparam logic [CODE_W-1:0] RESULT_MISMATCH  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROTOCOL   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_RATE = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAUD_ADJ   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_FD = 4'd3;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic              out_kind;
      logic [BYTE_W-1:0] tx_byte;
      logic [CODE_W-1:0] result_code;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic [NIBBLE_W-1:0] protocol;
      logic [BYTE_W-1:0]   request_fd;
      logic [BYTE_W-1:0]   default_fd;
   } cfg_view_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } status_type;

endpackage

FILE: design/spx_channels.sv
// Valid/ready channel interfaces of the PPS exchange block.
// Depends on spx_pkg for field widths.
interface spx_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [spx_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, kind, rx_byte, input ready);
   modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface spx_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        out_kind;
   logic [spx_pkg::BYTE_W-1:0]  tx_byte;
   logic [spx_pkg::CODE_W-1:0]  result_code;
   logic                        last;

   modport source (output valid, out_kind, tx_byte, result_code, last, input ready);
   modport sink   (input valid, out_kind, tx_byte, result_code, last, output ready);
endinterface

interface spx_csr_if;
   logic                            valid;
   logic                            ready;
   logic [spx_pkg::CSR_INDEX_W-1:0] index;
   logic [spx_pkg::BYTE_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/spx_parser.sv
// PPS response parser: tracks the card's reply byte by byte and decides the status.
// Depends on spx_pkg.
module spx_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  spx_pkg::req_item_type item,
   input  spx_pkg::cfg_view_type cfg,
   output spx_pkg::status_type   status
);
   import spx_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_PPSS, PH_PPS0, PH_PPS1, PH_PPS2, PH_PPS3, PH_PCK, PH_DONE
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [2:0]          opt_ff, opt_in;
   logic [BYTE_W-1:0]   accum_ff, accum_in;
   logic [NIBBLE_W-1:0] rproto_ff, rproto_in;
   logic [BYTE_W-1:0]   rfd_ff, rfd_in;
   logic                fd_seen_ff, fd_seen_in;
   logic                extra_ff, extra_in;
   logic [BYTE_W-1:0]   accum_x;
   logic                fd_ok;

   function automatic phase_type next_field(input logic [2:0] opt);
      phase_type ph;
      priority if (opt[0]) ph = PH_PPS1;
      else if (opt[1])     ph = PH_PPS2;
      else if (opt[2])     ph = PH_PPS3;
      else                 ph = PH_PCK;
      return ph;
   endfunction

   always_comb begin
      phase_in   = phase_ff;
      opt_in     = opt_ff;
      accum_in   = accum_ff;
      rproto_in  = rproto_ff;
      rfd_in     = rfd_ff;
      fd_seen_in = fd_seen_ff;
      extra_in   = extra_ff;
      status     = '0;
      accum_x    = accum_ff ^ item.rx_byte;
      fd_ok      = fd_seen_ff ? (rfd_ff == cfg.request_fd)
                              : (cfg.request_fd == cfg.default_fd);
      if (fire) begin
         if (item.kind == KIND_START) begin
            phase_in   = PH_PPSS;
            opt_in     = '0;
            accum_in   = '0;
            rproto_in  = '0;
            rfd_in     = '0;
            fd_seen_in = 1'b0;
            extra_in   = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_PPSS: begin
                  accum_in = item.rx_byte;
                  if (item.rx_byte != PPSS_BYTE) begin
                     status.valid = 1'b1;
                     status.code  = RESULT_BAD_PPSS;
                     phase_in     = PH_DONE;
                  end else begin
                     phase_in = PH_PPS0;
                  end
               end
               PH_PPS0: begin
                  accum_in  = accum_x;
                  rproto_in = item.rx_byte[NIBBLE_W-1:0];
                  opt_in    = item.rx_byte[6:4];
                  phase_in  = next_field(item.rx_byte[6:4]);
               end
               PH_PPS1: begin
                  accum_in   = accum_x;
                  rfd_in     = item.rx_byte;
                  fd_seen_in = 1'b1;
                  opt_in     = opt_ff & 3'b110;
                  phase_in   = next_field(opt_ff & 3'b110);
               end
               PH_PPS2: begin
                  accum_in = accum_x;
                  extra_in = 1'b1;
                  opt_in   = opt_ff & 3'b101;
                  phase_in = next_field(opt_ff & 3'b101);
               end
               PH_PPS3: begin
                  accum_in = accum_x;
                  extra_in = 1'b1;
                  opt_in   = opt_ff & 3'b011;
                  phase_in = next_field(opt_ff & 3'b011);
               end
               PH_PCK: begin
                  accum_in     = accum_x;
                  status.valid = 1'b1;
                  phase_in     = PH_DONE;
                  if (accum_x != '0) begin
                     status.code = RESULT_BAD_CHECK;
                  end else if ((rproto_ff == cfg.protocol) && fd_ok && !extra_ff) begin
                     status.code = RESULT_OK;
                  end else begin
                     status.code = RESULT_MISMATCH;
                  end
               end
               PH_IDLE, PH_DONE: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         opt_ff     <= '0;
         accum_ff   <= '0;
         rproto_ff  <= '0;
         rfd_ff     <= '0;
         fd_seen_ff <= 1'b0;
         extra_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         opt_ff     <= opt_in;
         accum_ff   <= accum_in;
         rproto_ff  <= rproto_in;
         rfd_ff     <= rfd_in;
         fd_seen_ff <= fd_seen_in;
         extra_ff   <= extra_in;
      end
   end

endmodule

FILE: design/smartcard_pps_exchange.sv
// Top level of the smart-card PPS exchange block: input register, register file,
// parser and result register. Depends on spx_pkg, spx_channels, spx_parser, assert_macros.svh.
//
// Channels: req_ch takes one transaction per item (kind 0 starts an exchange, kind 1
// carries a card byte). rsp_ch delivers result transactions: four request bytes
// (PPSS, PPS0, PPS1, PCK, the last one marked) per start, and one status per reply.
// csr_ch writes the four registers by index; it is always ready, unknown indexes
// are dropped. Write registers only while no exchange is in flight.
// Path: a transaction waits in the input register until it is processed; its first result
// is registered in the result register in the cycle after it is processed.
// Throughput: one card byte per cycle while rsp_ch is not held; a start occupies the result
// register for its four request bytes, so the next item waits on that burst.
// Reset: synchronous; clears both registers, the burst counter and the parser,
// and loads the register defaults (T=0, F=1, D=1, default F/D 0x11).
// Stall: while rsp_ch is held, the result register holds and one more item is
// captured in the input register before req_ch ready drops.
`include "assert_macros.svh"

module smartcard_pps_exchange (
   input logic          clock,
   input logic          reset,
   spx_req_if.sink      req_ch,
   spx_rsp_if.source    rsp_ch,
   spx_csr_if.sink      csr_ch
);
   import spx_pkg::*;

   logic [NIBBLE_W-1:0] protocol_ff;
   logic [NIBBLE_W-1:0] clock_rate_ff;
   logic [NIBBLE_W-1:0] baud_adj_ff;
   logic [BYTE_W-1:0]   default_fd_ff;

   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_item_ff, rsp_item_in;
   logic [2:0][BYTE_W-1:0]   burst_ff, burst_in;
   logic [1:0]               left_ff, left_in;

   logic          req_fire;
   logic          rsp_fire;
   logic          can_load;
   logic          consume;
   logic [BYTE_W-1:0] pps0_byte;
   cfg_view_type  cfg_view;
   status_type    status;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ch.ready;
   assign can_load  = !rsp_valid_ff || (rsp_ch.ready && (left_ff == '0));
   assign consume   = in_valid_ff && can_load;
   assign req_ch.ready = !in_valid_ff || can_load;
   assign csr_ch.ready = 1'b1;

   assign pps0_byte           = PPS0_BASE | {{(BYTE_W-NIBBLE_W){1'b0}}, protocol_ff};
   assign cfg_view.protocol   = protocol_ff;
   assign cfg_view.request_fd = {clock_rate_ff, baud_adj_ff};
   assign cfg_view.default_fd = default_fd_ff;

   spx_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (consume),
      .item   (in_item_ff),
      .cfg    (cfg_view),
      .status (status)
   );

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_ff   <= 4'd0;
         clock_rate_ff <= 4'd1;
         baud_adj_ff   <= 4'd1;
         default_fd_ff <= 8'h11;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_PROTOCOL:   protocol_ff   <= csr_ch.data[NIBBLE_W-1:0];
            CSR_CLOCK_RATE: clock_rate_ff <= csr_ch.data[NIBBLE_W-1:0];
            CSR_BAUD_ADJ:   baud_adj_ff   <= csr_ch.data[NIBBLE_W-1:0];
            CSR_DEFAULT_FD: default_fd_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_item_ff.kind    <= req_ch.kind;
         in_item_ff.rx_byte <= req_ch.rx_byte;
      end
   end

   // result register and request burst
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      burst_in     = burst_ff;
      left_in      = left_ff;
      if (consume && (in_item_ff.kind == KIND_START)) begin
         rsp_valid_in            = 1'b1;
         rsp_item_in.out_kind    = OUT_REQUEST;
         rsp_item_in.tx_byte     = PPSS_BYTE;
         rsp_item_in.result_code = RESULT_OK;
         rsp_item_in.last        = 1'b0;
         burst_in[0]             = pps0_byte;
         burst_in[1]             = cfg_view.request_fd;
         burst_in[2]             = PPSS_BYTE ^ pps0_byte ^ cfg_view.request_fd;
         left_in                 = 2'(REQ_BYTES - 1);
      end else if (consume && status.valid) begin
         rsp_valid_in            = 1'b1;
         rsp_item_in.out_kind    = OUT_STATUS;
         rsp_item_in.tx_byte     = '0;
         rsp_item_in.result_code = status.code;
         rsp_item_in.last        = 1'b1;
         left_in                 = '0;
      end else if (rsp_fire && (left_ff != '0)) begin
         rsp_item_in.out_kind    = OUT_REQUEST;
         rsp_item_in.tx_byte     = burst_ff[0];
         rsp_item_in.result_code = RESULT_OK;
         rsp_item_in.last        = (left_ff == 2'd1);
         burst_in                = {{BYTE_W{1'b0}}, burst_ff[2:1]};
         left_in                 = left_ff - 2'd1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
      end
      rsp_item_ff <= rsp_item_in;
      burst_ff    <= burst_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_kind    = rsp_item_ff.out_kind;
   assign rsp_ch.tx_byte     = rsp_item_ff.tx_byte;
   assign rsp_ch.result_code = rsp_item_ff.result_code;
   assign rsp_ch.last        = rsp_item_ff.last;

   `ASSERT_ALWAYS(a_burst_needs_valid, (left_ff != '0) |-> rsp_valid_ff, "burst pending without valid result")
   `ASSERT_RST(a_last_ends_burst, (rsp_valid_ff && !rsp_item_ff.last) |-> (left_ff != '0), "unmarked result with no burst behind it")
   `ASSERT_RST(a_status_is_last, (rsp_valid_ff && (rsp_item_ff.out_kind == OUT_STATUS)) |-> (rsp_item_ff.last && (left_ff == '0)), "status not marked last")
   `ASSERT_RST(a_start_loads_ppss, (consume && (in_item_ff.kind == KIND_START)) |=> (rsp_valid_ff && (left_ff == 2'd3) && (rsp_item_ff.tx_byte == PPSS_BYTE)), "start did not load PPSS")

endmodule

FILE: dv/pps_exchange_checker.sv
`timescale 1ns / 1ps
// Checker for the smart-card PPS exchange block: watches the request, result and
// register channels, predicts the request bytes and exchange status, and counts mismatches.
// Depends on spx_pkg and the channel interfaces in spx_channels.
module pps_exchange_checker
   import spx_pkg::*;
(
   input  logic clock,
   input  logic reset,
   spx_req_if   req_ch,
   spx_rsp_if   rsp_ch,
   spx_csr_if   csr_ch,
   output int   mismatch_count,
   output int   outstanding
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_PPSS, PH_PPS0, PH_PPS1, PH_PPS2, PH_PPS3, PH_PCK, PH_DONE
   } pps_phase_e;

   logic [NIBBLE_W-1:0] cfg_protocol;
   logic [NIBBLE_W-1:0] cfg_f_index;
   logic [NIBBLE_W-1:0] cfg_d_index;
   logic [BYTE_W-1:0]   cfg_default_fd;

   pps_phase_e          phase_q;
   logic [2:0]          optional_left;
   logic [BYTE_W-1:0]   xor_accum;
   logic [NIBBLE_W-1:0] card_protocol;
   logic [BYTE_W-1:0]   card_fd;
   logic                card_fd_seen;
   logic                card_extra_seen;

   rsp_item_type exchange_out_q[$];

   function automatic pps_phase_e next_optional(input logic [2:0] left);
      if (left[0]) return PH_PPS1;
      if (left[1]) return PH_PPS2;
      if (left[2]) return PH_PPS3;
      return PH_PCK;
   endfunction

   function automatic logic [BYTE_W-1:0] proposed_fd();
      return {cfg_f_index, cfg_d_index};
   endfunction

   task automatic queue_result(input logic kind, input logic [BYTE_W-1:0] tx,
                               input logic [CODE_W-1:0] code, input logic last);
      rsp_item_type item;
      item.out_kind    = kind;
      item.tx_byte     = tx;
      item.result_code = code;
      item.last        = last;
      exchange_out_q.push_back(item);
   endtask

   task automatic queue_status(input logic [CODE_W-1:0] code);
      queue_result(OUT_STATUS, '0, code, 1'b1);
      phase_q = PH_DONE;
   endtask

   task automatic clear_reply();
      optional_left   = '0;
      xor_accum       = '0;
      card_protocol   = '0;
      card_fd         = '0;
      card_fd_seen    = 1'b0;
      card_extra_seen = 1'b0;
   endtask

   task automatic advance_exchange(input logic kind, input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] req_pps0;
      logic [BYTE_W-1:0] req_fd;
      logic              agree;
      if (kind == KIND_START) begin
         req_pps0 = PPS0_BASE | {4'h0, cfg_protocol};
         req_fd   = proposed_fd();
         queue_result(OUT_REQUEST, PPSS_BYTE, RESULT_OK, 1'b0);
         queue_result(OUT_REQUEST, req_pps0, RESULT_OK, 1'b0);
         queue_result(OUT_REQUEST, req_fd, RESULT_OK, 1'b0);
         queue_result(OUT_REQUEST, PPSS_BYTE ^ req_pps0 ^ req_fd, RESULT_OK, 1'b1);
         phase_q = PH_PPSS;
         clear_reply();
      end else begin
         case (phase_q)
            PH_PPSS: begin
               xor_accum = b;
               if (b != PPSS_BYTE) queue_status(RESULT_BAD_PPSS);
               else phase_q = PH_PPS0;
            end
            PH_PPS0: begin
               xor_accum     ^= b;
               card_protocol = b[3:0];
               optional_left = b[6:4];
               phase_q       = next_optional(optional_left);
            end
            PH_PPS1: begin
               xor_accum     ^= b;
               card_fd       = b;
               card_fd_seen  = 1'b1;
               optional_left &= 3'b110;
               phase_q       = next_optional(optional_left);
            end
            PH_PPS2, PH_PPS3: begin
               xor_accum       ^= b;
               card_extra_seen = 1'b1;
               optional_left   &= (phase_q == PH_PPS2) ? 3'b101 : 3'b011;
               phase_q         = next_optional(optional_left);
            end
            PH_PCK: begin
               xor_accum ^= b;
               if (xor_accum != 8'h00) begin
                  queue_status(RESULT_BAD_CHECK);
               end else begin
                  agree = (card_protocol == cfg_protocol);
                  if (card_fd_seen) begin
                     if (card_fd != proposed_fd()) agree = 1'b0;
                  end else if (proposed_fd() != cfg_default_fd) begin
                     agree = 1'b0;
                  end
                  if (card_extra_seen) agree = 1'b0;
                  queue_status(agree ? RESULT_OK : RESULT_MISMATCH);
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic check_result();
      rsp_item_type got;
      rsp_item_type want;
      got.out_kind    = rsp_ch.out_kind;
      got.tx_byte     = rsp_ch.tx_byte;
      got.result_code = rsp_ch.result_code;
      got.last        = rsp_ch.last;
      if (exchange_out_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: result with nothing expected: kind %0b tx %h code %0d last %0b",
                     $realtime, got.out_kind, got.tx_byte, got.result_code, got.last);
      end else begin
         want = exchange_out_q.pop_front();
         if (got.out_kind !== want.out_kind || got.tx_byte !== want.tx_byte ||
             got.result_code !== want.result_code || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: mismatch: expected kind %0b tx %h code %0d last %0b, %s%0b %h %0d %0b",
                        $realtime, want.out_kind, want.tx_byte, want.result_code, want.last,
                        "got ", got.out_kind, got.tx_byte, got.result_code, got.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_protocol   = 4'd0;
         cfg_f_index    = 4'd1;
         cfg_d_index    = 4'd1;
         cfg_default_fd = 8'h11;
         phase_q        = PH_IDLE;
         clear_reply();
         exchange_out_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_PROTOCOL:   cfg_protocol   = csr_ch.data[NIBBLE_W-1:0];
               CSR_CLOCK_RATE: cfg_f_index    = csr_ch.data[NIBBLE_W-1:0];
               CSR_BAUD_ADJ:   cfg_d_index    = csr_ch.data[NIBBLE_W-1:0];
               CSR_DEFAULT_FD: cfg_default_fd = csr_ch.data;
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) check_result();
         if (req_ch.valid && req_ch.ready) advance_exchange(req_ch.kind, req_ch.rx_byte);
      end
      outstanding = exchange_out_q.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for smartcard_pps_exchange: clock, reset, stimulus and verdict.
// Depends on spx_pkg, spx_channels, the design and pps_exchange_checker.
module tb;
   import spx_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int SET_ITEMS     = 58;

   logic clock;
   logic reset;
   int   req_idle_pct;
   int   rsp_idle_pct;
   int   items_sent;
   int   cycle_count;
   int   mismatch_count;
   int   outstanding;

   logic [NIBBLE_W-1:0] cur_protocol;
   logic [NIBBLE_W-1:0] cur_f;
   logic [NIBBLE_W-1:0] cur_d;

   spx_req_if req_ch();
   spx_rsp_if rsp_ch();
   spx_csr_if csr_ch();

   smartcard_pps_exchange dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pps_exchange_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(negedge clock) rsp_ch.ready <= (int'($urandom_range(99)) >= rsp_idle_pct);

   task automatic send_req(input logic kind, input logic [BYTE_W-1:0] data, input bit counted);
      @(negedge clock);
      while (int'($urandom_range(99)) < req_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.kind    = kind;
      req_ch.rx_byte = data;
      do @(posedge clock); while (!req_ch.ready);
      if (counted) items_sent++;
   endtask

   task automatic card(input logic [BYTE_W-1:0] b);
      send_req(KIND_BYTE, b, 1'b1);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [BYTE_W-1:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data  = data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic apply_settings(input logic [3:0] p, input logic [3:0] f, input logic [3:0] d,
                                 input logic [7:0] dfd);
      write_csr(CSR_PROTOCOL, {4'($urandom_range(15)), p});
      write_csr(CSR_CLOCK_RATE, {4'($urandom_range(15)), f});
      write_csr(CSR_BAUD_ADJ, {4'($urandom_range(15)), d});
      write_csr(CSR_DEFAULT_FD, dfd);
      // unknown index, must be dropped
      write_csr(CSR_INDEX_W'($urandom_range(15, 4)), 8'($urandom));
      @(negedge clock);
      csr_ch.valid = 1'b0;
      cur_protocol = p;
      cur_f        = f;
      cur_d        = d;
   endtask

   task automatic random_exchange();
      logic [BYTE_W-1:0] reply[$];
      logic [BYTE_W-1:0] sum;
      logic [2:0]        opt;
      logic [3:0]        proto;
      int                cut;
      send_req(KIND_START, 8'($urandom), 1'b1);
      reply.push_back(($urandom_range(99) < 95) ? PPSS_BYTE : 8'($urandom));
      case ($urandom_range(9))
         0, 1, 2, 3, 4: opt = 3'b001;
         5, 6:          opt = 3'b000;
         default:       opt = 3'($urandom);
      endcase
      proto = ($urandom_range(99) < 80) ? cur_protocol : 4'($urandom);
      reply.push_back({1'($urandom), opt, proto});
      if (opt[0]) reply.push_back(($urandom_range(99) < 80) ? {cur_f, cur_d} : 8'($urandom));
      if (opt[1]) reply.push_back(8'($urandom));
      if (opt[2]) reply.push_back(8'($urandom));
      sum = '0;
      foreach (reply[i]) sum ^= reply[i];
      if ($urandom_range(99) < 15) sum ^= 8'($urandom_range(255, 1));
      reply.push_back(sum);
      cut = reply.size();
      if ($urandom_range(99) < 8) cut = $urandom_range(reply.size() - 1, 0);
      for (int i = 0; i < cut; i++) card(reply[i]);
      if (cut == reply.size() && $urandom_range(99) < 15)
         repeat ($urandom_range(2, 1)) send_req(KIND_BYTE, 8'($urandom), 1'b0);
   endtask

   task automatic run_random(input int count);
      int first;
      int pick;
      first = items_sent;
      while (items_sent - first < count) begin
         if ($urandom_range(99) < 3) wait_quiet();
         pick = $urandom_range(99);
         if (pick < 78) begin
            random_exchange();
         end else if (pick < 90) begin
            send_req(1'($urandom), 8'($urandom), 1'b1);
         end else begin
            send_req(KIND_START, 8'($urandom), 1'b1);
            card(PPSS_BYTE);
            repeat ($urandom_range(3)) card(8'($urandom));
         end
      end
   endtask

   initial begin
      logic [3:0] f;
      logic [3:0] d;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_START;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = '0;
      csr_ch.data    = '0;
      req_idle_pct   = 20;
      rsp_idle_pct   = 70;
      items_sent     = 0;
      cycle_count    = 0;
      cur_protocol   = 4'd0;
      cur_f          = 4'd1;
      cur_d          = 4'd1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset defaults: T=0, F/D 0x11, default F/D 0x11
      card(8'hFF);
      send_req(KIND_START, 8'hFF, 1'b1);
      card(8'hFF); card(8'h10); card(8'h11); card(8'hFE);
      send_req(KIND_START, 8'h00, 1'b1);
      card(8'h00); card(8'hFF);
      send_req(KIND_START, 8'h00, 1'b1);
      card(8'hFF); card(8'h00); card(8'hFF);
      send_req(KIND_START, 8'h00, 1'b1);
      card(8'hFF); card(8'h10); card(8'h11); card(8'h00);
      send_req(KIND_START, 8'h00, 1'b1);
      card(8'hFF); card(8'h61); card(8'h22); card(8'h33); card(8'h8F);
      send_req(KIND_START, 8'h00, 1'b1);
      card(8'hFF);
      send_req(KIND_START, 8'h00, 1'b1);
      card(8'hFF); card(8'h00); card(8'hFF);

      wait_quiet();
      apply_settings(4'd0, 4'd0, 4'd0, 8'h00);
      run_random(SET_ITEMS);
      wait_quiet();
      apply_settings(4'd15, 4'd15, 4'd15, 8'hFF);
      run_random(SET_ITEMS);

      req_idle_pct = 70;
      rsp_idle_pct = 20;
      wait_quiet();
      apply_settings(4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom));
      run_random(SET_ITEMS);
      wait_quiet();
      apply_settings(4'd1, 4'd9, 4'd4, 8'h94);
      run_random(SET_ITEMS);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      wait_quiet();
      f = 4'($urandom);
      d = 4'($urandom);
      apply_settings(4'($urandom), f, d, {f, d});
      run_random(SET_ITEMS);
      wait_quiet();
      apply_settings(4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom));
      run_random(SET_ITEMS);
      wait_quiet();

      if (mismatch_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/spx_pkg.sv
design/spx_channels.sv
design/spx_parser.sv
design/smartcard_pps_exchange.sv
dv/pps_exchange_checker.sv
dv/tb.sv
